// ----- rtl/cft_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants of the CSV field tokenizer
// Result kinds, character codes and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package cft_pkg;

	localparam int REC_W = 9;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_FIELD  = 2'd1,
		KIND_RECORD = 2'd2
	} kind_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	typedef struct packed {
		logic latch;       // capture the accepted request
		logic use_held;    // work on the captured byte, not the port
		logic do_byte;     // run the byte step on the current byte
		logic do_eol;      // close the line, emit the record end
		logic rd_start;    // rewind the whitespace read index
		logic rd_issue;    // read one held whitespace byte
		logic flush_emit;  // emit the held byte just read
	} cmd_t;

	typedef struct packed {
		logic is_nl;
		logic cur_eot;
		logic need_flush;
		logic flush_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/cft_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cft_if: channel interfaces of the CSV field tokenizer
// Text byte channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface cft_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] field_number;
	logic       is_header;
	logic [8:0] fields_in_record;
	logic [8:0] widest_record;
	logic       space_overflow;
	logic       last_of_run;

	modport source (
		output valid, output kind, output data_byte, output field_number,
		output is_header, output fields_in_record, output widest_record,
		output space_overflow, output last_of_run, input ready
	);
	modport sink (
		input valid, input kind, input data_byte, input field_number,
		input is_header, input fields_in_record, input widest_record,
		input space_overflow, input last_of_run, output ready
	);
endinterface
`default_nettype wire

// ----- rtl/csv_field_tokenizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csv_field_tokenizer: streaming CSV field tokenizer
// Splits a text byte stream into data bytes, field ends and record ends,
// with quoting, backslash escapes, header marks and whitespace trimming.
//
//   channel  modport  payload                                      request
//   text     sink     in_byte, end_of_text                          one byte
//   token    source   kind, data_byte, field_number, is_header,     one result
//                     fields_in_record, widest_record,
//                     space_overflow, last_of_run
//
// A plain byte is parsed in the cycle that accepts it. A byte that releases
// held whitespace passes through the accept step, one buffer read and one
// result slot per held byte, and a step for the byte itself. End of text
// on a byte other than newline adds a step for the record end. Reset
// needs no clearing pass.
// The single result register stalls the text side while a result waits.
// ----------------------------------------------------------------------------
module csv_field_tokenizer import cft_pkg::*; #(
	parameter int SPACE_DEPTH = 16,
	parameter int MAX_FIELDS  = 256
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cft_in_if.sink    text,
	cft_out_if.source token
);

	cmd_t cmd;
	sts_t sts;

	cft_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text.valid),
		.text_ready (text.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	cft_dp #(
		.SPACE_DEPTH (SPACE_DEPTH),
		.MAX_FIELDS  (MAX_FIELDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (text.in_byte),
		.end_of_text (text.end_of_text),
		.cmd         (cmd),
		.sts         (sts),
		.token       (token)
	);

endmodule
`default_nettype wire

// ----- rtl/cft_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cft_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cft_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cft_ctrl: sequencer of the CSV field tokenizer
// Accepts text bytes, walks held whitespace out of the buffer and closes
// lines, driving the datapath by command bits.
// ----------------------------------------------------------------------------
module cft_ctrl import cft_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic text_valid,
	output logic      text_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLUSH_RD,
		S_FLUSH_WR,
		S_BYTE,
		S_EOL
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		text_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				text_ready = sts.out_free;
				if (text_valid && sts.out_free) begin
					cmd.latch = 1'b1;
					if (sts.is_nl) begin
						cmd.do_eol = 1'b1;
					end else if (sts.need_flush) begin
						cmd.rd_start = 1'b1;
						state_d      = S_FLUSH_RD;
					end else begin
						cmd.do_byte = 1'b1;
						if (sts.cur_eot) begin
							state_d = S_EOL;
						end
					end
				end
			end
			S_FLUSH_RD: begin
				cmd.use_held = 1'b1;
				cmd.rd_issue = 1'b1;
				state_d      = S_FLUSH_WR;
			end
			S_FLUSH_WR: begin
				cmd.use_held = 1'b1;
				if (sts.out_free) begin
					cmd.flush_emit = 1'b1;
					state_d        = sts.flush_last ? S_BYTE : S_FLUSH_RD;
				end
			end
			S_BYTE: begin
				cmd.use_held = 1'b1;
				if (sts.out_free) begin
					cmd.do_byte = 1'b1;
					state_d     = sts.cur_eot ? S_EOL : S_IDLE;
				end
			end
			S_EOL: begin
				cmd.use_held = 1'b1;
				if (sts.out_free) begin
					cmd.do_eol = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_byte, cmd.do_eol, cmd.rd_start, cmd.rd_issue, cmd.flush_emit}))
		else $error("cft_ctrl: more than one datapath action in a cycle");

	a_eol_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EOL) |-> sts.cur_eot)
		else $error("cft_ctrl: record-end state without end of text");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH_WR && $past(state_q) != S_FLUSH_WR)
			|-> $past(state_q) == S_FLUSH_RD)
		else $error("cft_ctrl: buffer emit without a preceding read");

endmodule
`default_nettype wire

// ----- rtl/cft_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cft_dp: datapath of the CSV field tokenizer
// Line and quote state, field and width counters, the whitespace buffer
// and the result register.
// ----------------------------------------------------------------------------
module cft_dp import cft_pkg::*; #(
	parameter int SPACE_DEPTH = 16,
	parameter int MAX_FIELDS  = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	input  wire cmd_t       cmd,
	output sts_t            sts,
	cft_out_if.source       token
);

	localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
	localparam int CW = $clog2(SPACE_DEPTH + 1);
	localparam int FW = $clog2(MAX_FIELDS);
	localparam int NW = ((FW > REC_W) ? FW : REC_W) + 1;
	localparam logic [FW-1:0] FC_MAX = FW'(MAX_FIELDS - 1);

	// held request
	logic [7:0]       byte_q;
	logic             eot_q;
	// line state
	logic             quoting_q, escaping_q, line_start_q, header_q, overflow_q;
	logic [FW-1:0]    fc_q;
	logic [REC_W-1:0] widest_q;
	logic [CW-1:0]    pcount_q;
	logic [AW-1:0]    idx_q;
	// result register
	logic             ovalid_q;
	kind_t            okind_q;
	logic [7:0]       odata_q, ofield_q;
	logic             ohdr_q, oovf_q, olast_q;
	logic [REC_W-1:0] orec_q, owide_q;

	logic [7:0]       cur_b, ram_rd;
	logic             cur_eot, cur_ws, out_free;
	logic [NW-1:0]    fc_wide, rec_n;
	logic [7:0]       field_num;
	logic [REC_W-1:0] rec_sat, wide_max;
	logic             p_emit, p_toggle, p_esc_set, p_esc_clr, p_fc_inc;
	kind_t            p_kind;
	logic [7:0]       p_data;
	logic             bs_parse, bs_push, bs_hash, bs_clear;
	logic             push_ok, flush_last, flush_tail;
	logic             load;
	kind_t            l_kind;
	logic [7:0]       l_data;
	logic [REC_W-1:0] l_rec, l_wide;
	logic             l_last;

	cft_ram #(.WIDTH(8), .DEPTH(SPACE_DEPTH)) u_space (
		.clk     (clk),
		.wr_en   (cmd.do_byte && bs_push && push_ok),
		.wr_addr (pcount_q[AW-1:0]),
		.wr_data (cur_b),
		.rd_en   (cmd.rd_issue),
		.rd_addr (idx_q),
		.rd_data (ram_rd)
	);

	always_comb begin
		cur_b   = cmd.use_held ? byte_q : in_byte;
		cur_eot = cmd.use_held ? eot_q : end_of_text;
		cur_ws  = cur_b inside {CH_SPACE, [CH_TAB:CH_CR]};

		fc_wide   = NW'(fc_q);
		field_num = (fc_wide > NW'(255)) ? 8'hFF : fc_wide[7:0];
		rec_n     = fc_wide + NW'(1);
		rec_sat   = (rec_n > NW'(511)) ? 9'h1FF : rec_n[REC_W-1:0];
		wide_max  = (rec_sat > widest_q) ? rec_sat : widest_q;

		// parse of one byte against the quote state
		p_emit    = 1'b0;
		p_kind    = KIND_DATA;
		p_data    = cur_b;
		p_toggle  = 1'b0;
		p_esc_set = 1'b0;
		p_esc_clr = 1'b0;
		p_fc_inc  = 1'b0;
		if (escaping_q) begin
			p_esc_clr = 1'b1;
			p_emit    = 1'b1;
			case (cur_b)
				CH_T:    p_data = CH_TAB;
				CH_R:    p_data = CH_CR;
				CH_N:    p_data = CH_LF;
				default: p_data = cur_b;
			endcase
		end else begin
			case (cur_b)
				CH_QUOTE: begin
					p_toggle = 1'b1;
				end
				CH_BSLASH: begin
					p_esc_set = quoting_q;
					p_emit    = !quoting_q;
				end
				CH_COMMA: begin
					p_emit = 1'b1;
					if (!quoting_q) begin
						p_kind   = KIND_FIELD;
						p_data   = 8'h00;
						p_fc_inc = 1'b1;
					end
				end
				default: begin
					p_emit = 1'b1;
				end
			endcase
		end

		// byte step: skip leading blanks, mark a leading hash as header, hold trailing ones, parse the rest
		bs_parse = 1'b0;
		bs_push  = 1'b0;
		bs_hash  = 1'b0;
		bs_clear = 1'b0;
		if (line_start_q) begin
			if (!cur_ws) begin
				bs_hash  = (cur_b == CH_HASH);
				bs_parse = (cur_b != CH_HASH);
			end
		end else if (cur_ws) begin
			bs_push = 1'b1;
		end else begin
			bs_parse = 1'b1;
			bs_clear = 1'b1;
		end
		push_ok = (pcount_q != CW'(SPACE_DEPTH));

		// the last held byte closes the step only if the byte behind it is silent
		flush_last = ((CW'(idx_q) + CW'(1)) == pcount_q);
		flush_tail = flush_last && !eot_q &&
			(byte_q == CH_QUOTE || (byte_q == CH_BSLASH && quoting_q));

		out_free = !ovalid_q || token.ready;

		sts.is_nl      = (cur_b == CH_LF);
		sts.cur_eot    = cur_eot;
		sts.need_flush = !sts.is_nl && !line_start_q && !cur_ws && (pcount_q != '0);
		sts.flush_last = flush_last;
		sts.out_free   = out_free;

		load   = cmd.do_eol || cmd.flush_emit || (cmd.do_byte && bs_parse && p_emit);
		l_kind = p_kind;
		l_data = p_data;
		l_rec  = '0;
		l_wide = widest_q;
		l_last = !cur_eot;
		if (cmd.do_eol) begin
			l_kind = KIND_RECORD;
			l_data = 8'h00;
			l_rec  = rec_sat;
			l_wide = wide_max;
			l_last = 1'b1;
		end else if (cmd.flush_emit) begin
			l_kind = KIND_DATA;
			l_data = ram_rd;
			l_last = flush_tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoting_q    <= 1'b0;
			escaping_q   <= 1'b0;
			line_start_q <= 1'b1;
			header_q     <= 1'b0;
			overflow_q   <= 1'b0;
			fc_q         <= '0;
			widest_q     <= '0;
			pcount_q     <= '0;
			idx_q        <= '0;
			ovalid_q     <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (token.ready) begin
				ovalid_q <= 1'b0;
			end

			if (cmd.rd_start) begin
				idx_q <= '0;
			end
			if (cmd.flush_emit) begin
				idx_q      <= idx_q + AW'(1);
				escaping_q <= 1'b0;
			end

			if (cmd.do_byte) begin
				if (line_start_q && !cur_ws) begin
					line_start_q <= 1'b0;
				end
				if (bs_hash) begin
					header_q <= 1'b1;
				end
				if (bs_push) begin
					if (push_ok) begin
						pcount_q <= pcount_q + CW'(1);
					end else begin
						overflow_q <= 1'b1;
					end
				end
				if (bs_clear) begin
					pcount_q <= '0;
				end
				if (bs_parse) begin
					quoting_q <= quoting_q ^ p_toggle;
					if (p_esc_set) begin
						escaping_q <= 1'b1;
					end else if (p_esc_clr) begin
						escaping_q <= 1'b0;
					end
					if (p_fc_inc && fc_q != FC_MAX) begin
						fc_q <= fc_q + FW'(1);
					end
				end
			end

			if (cmd.do_eol) begin
				// a new text starts a fresh width count
				widest_q     <= cur_eot ? '0 : wide_max;
				quoting_q    <= 1'b0;
				escaping_q   <= 1'b0;
				fc_q         <= '0;
				pcount_q     <= '0;
				line_start_q <= 1'b1;
				header_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= in_byte;
			eot_q  <= end_of_text;
		end
		if (load) begin
			okind_q  <= l_kind;
			odata_q  <= l_data;
			ofield_q <= field_num;
			ohdr_q   <= header_q;
			orec_q   <= l_rec;
			owide_q  <= l_wide;
			oovf_q   <= overflow_q;
			olast_q  <= l_last;
		end
	end

	assign token.valid            = ovalid_q;
	assign token.kind             = okind_q;
	assign token.data_byte        = odata_q;
	assign token.field_number     = ofield_q;
	assign token.is_header        = ohdr_q;
	assign token.fields_in_record = orec_q;
	assign token.widest_record    = owide_q;
	assign token.space_overflow   = oovf_q;
	assign token.last_of_run      = olast_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!ovalid_q || token.ready))
		else $error("cft_dp: result overwritten before it was taken");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_emit |-> (pcount_q != '0) && (CW'(idx_q) < pcount_q))
		else $error("cft_dp: buffer read past the held whitespace");

	a_eol_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_eol |=> line_start_q && !quoting_q && !escaping_q && (pcount_q == '0))
		else $error("cft_dp: line state not cleared at record end");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CSV field tokenizer
// Streams directed and random text lines into the text channel and checks
// every token against an in-bench tokenizer model. Both handshakes idle at
// random, except for one stretch of full throughput.
// ----------------------------------------------------------------------------
module tb_top import cft_pkg::*; ();

	localparam int SPACE_DEPTH  = 16;
	localparam int MAX_FIELDS   = 256;
	localparam int MAX_TOKENS   = SPACE_DEPTH + 2;
	localparam int RAND_BYTES   = 160;
	localparam int DRAIN_CYCLES = 2 * SPACE_DEPTH + 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;
	localparam int IDLE_PCT     = 17;

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_req_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] field_number;
		logic       is_header;
		logic [8:0] fields_in_record;
		logic [8:0] widest_record;
		logic       space_overflow;
		logic       last_of_run;
	} token_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       drv_valid = 1'b0;
	logic [7:0] drv_byte  = '0;
	logic       drv_eot   = 1'b0;
	logic       drv_ready = 1'b0;
	logic       calm;

	cft_in_if  text_ch();
	cft_out_if tok_ch();

	assign text_ch.valid       = drv_valid;
	assign text_ch.in_byte     = drv_byte;
	assign text_ch.end_of_text = drv_eot;
	assign tok_ch.ready        = drv_ready;

	csv_field_tokenizer #(
		.SPACE_DEPTH(SPACE_DEPTH),
		.MAX_FIELDS (MAX_FIELDS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_ch),
		.token (tok_ch)
	);

	text_req_t   pending_text[$];
	token_t      expected_tokens[$];
	text_req_t   next_req;
	token_t      got, want;
	int unsigned accepted_bytes = 0;
	int unsigned cycle_cnt      = 0;
	int unsigned err_cnt        = 0;
	int unsigned tok_idx        = 0;

	// tokenizer model state
	logic       in_quotes     = 1'b0;
	logic       after_bslash  = 1'b0;
	logic       at_line_start = 1'b1;
	logic       hdr_line      = 1'b0;
	logic       ws_overflow   = 1'b0;
	logic [7:0] field_idx     = '0;
	logic [8:0] widest        = '0;
	logic [7:0] held_ws[SPACE_DEPTH];
	int         held_cnt      = 0;
	token_t     step_toks[MAX_TOKENS];
	int         step_cnt;

	// full throughput on both sides for a stretch of the run
	assign calm = accepted_bytes >= 300 && accepted_bytes < 420;

	function automatic logic is_blank(logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic void add_token(kind_t k, logic [7:0] d, logic [8:0] n);
		if (step_cnt < MAX_TOKENS) begin
			step_toks[step_cnt] = '{k, d, field_idx, hdr_line, n, widest, ws_overflow, 1'b0};
			step_cnt++;
		end
	endfunction

	function automatic void decode_char(logic [7:0] b);
		logic [7:0] c;
		c = b;
		if (after_bslash) begin
			if (b == CH_T)
				c = CH_TAB;
			else if (b == CH_R)
				c = CH_CR;
			else if (b == CH_N)
				c = CH_LF;
			after_bslash = 1'b0;
			add_token(KIND_DATA, c, '0);
		end else if (b == CH_QUOTE) begin
			in_quotes = !in_quotes;
		end else if (b == CH_BSLASH) begin
			if (in_quotes)
				after_bslash = 1'b1;
			else
				add_token(KIND_DATA, b, '0);
		end else if (b == CH_COMMA && !in_quotes) begin
			add_token(KIND_FIELD, '0, '0);
			if (field_idx < MAX_FIELDS - 1)
				field_idx++;
		end else begin
			add_token(KIND_DATA, b, '0);
		end
	endfunction

	function automatic void close_record();
		logic [8:0] n;
		n = {1'b0, field_idx} + 9'd1;
		if (n > widest)
			widest = n;
		add_token(KIND_RECORD, '0, n);
		in_quotes     = 1'b0;
		after_bslash  = 1'b0;
		field_idx     = '0;
		held_cnt      = 0;
		at_line_start = 1'b1;
		hdr_line      = 1'b0;
	endfunction

	function automatic void predict_tokens(logic [7:0] b, logic eot);
		step_cnt = 0;
		if (b == CH_LF) begin
			close_record();
		end else begin
			if (at_line_start) begin
				if (!is_blank(b)) begin
					at_line_start = 1'b0;
					if (b == CH_HASH)
						hdr_line = 1'b1;
					else
						decode_char(b);
				end
			end else if (is_blank(b)) begin
				// hold trailing whitespace until a later byte proves it is inside the field
				if (held_cnt < SPACE_DEPTH) begin
					held_ws[held_cnt] = b;
					held_cnt++;
				end else begin
					ws_overflow = 1'b1;
				end
			end else begin
				for (int i = 0; i < held_cnt; i++)
					decode_char(held_ws[i]);
				held_cnt = 0;
				decode_char(b);
			end
			if (eot)
				close_record();
		end
		if (eot)
			widest = '0;
		if (step_cnt > 0)
			step_toks[step_cnt - 1].last_of_run = 1'b1;
		for (int i = 0; i < step_cnt; i++)
			expected_tokens.insert(expected_tokens.size(), step_toks[i]);
	endfunction

	function automatic string tok_str(token_t t);
		return $sformatf("kind=%0d data=%02h field=%0d hdr=%0d n=%0d widest=%0d ovf=%0d last=%0d",
			t.kind, t.data_byte, t.field_number, t.is_header, t.fields_in_record,
			t.widest_record, t.space_overflow, t.last_of_run);
	endfunction

	function automatic void report_failure(string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("token %0d: %s", tok_idx, msg);
	endfunction

	function automatic void add_byte(logic [7:0] b, logic eot);
		pending_text.insert(pending_text.size(), text_req_t'{b, eot});
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], 1'b0);
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 4))
			0: return CH_TAB;
			1: return CH_VT;
			2: return CH_FF;
			3: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(128, 255));
		c = 8'($urandom_range(33, 126));
		if (c == CH_QUOTE || c == CH_COMMA)
			c = CH_HASH;
		return c;
	endfunction

	function automatic logic [7:0] escaped_char();
		case ($urandom_range(0, 5))
			0: return CH_T;
			1: return CH_R;
			2: return CH_N;
			3: return CH_QUOTE;
			4: return CH_BSLASH;
			default: return plain_char();
		endcase
	endfunction

	// one text line: mostly well-formed records, some raw noise
	function automatic void add_random_line();
		logic [7:0] line[$];
		int         nfields;
		logic       eot_last;
		eot_last = 1'b0;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				add_byte(8'($urandom), $urandom_range(0, 19) == 0);
			return;
		end
		repeat ($urandom_range(0, 3))
			line.insert(line.size(), rand_blank());
		if ($urandom_range(0, 4) == 0)
			line.insert(line.size(), CH_HASH);
		nfields = $urandom_range(1, 6);
		for (int f = 0; f < nfields; f++) begin
			if (f > 0)
				line.insert(line.size(), CH_COMMA);
			if ($urandom_range(0, 2) == 0) begin
				line.insert(line.size(), CH_QUOTE);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 5))
						0: begin
							line.insert(line.size(), CH_BSLASH);
							line.insert(line.size(), escaped_char());
						end
						1: line.insert(line.size(), CH_COMMA);
						2: line.insert(line.size(), rand_blank());
						default: line.insert(line.size(), plain_char());
					endcase
				end
				// leave the quote open now and then
				if ($urandom_range(0, 9) != 0)
					line.insert(line.size(), CH_QUOTE);
			end else begin
				repeat ($urandom_range(0, 5)) begin
					if ($urandom_range(0, 5) == 0)
						line.insert(line.size(), rand_blank());
					else
						line.insert(line.size(), plain_char());
				end
			end
			case ($urandom_range(0, 11))
				0, 1, 2: repeat ($urandom_range(1, 4)) line.insert(line.size(), rand_blank());
				3: repeat ($urandom_range(SPACE_DEPTH - 2, SPACE_DEPTH + 4))
					line.insert(line.size(), rand_blank());
				default: ;
			endcase
		end
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				line.insert(line.size(), CH_LF);
				eot_last = 1'b1;
			end
			3, 4: begin
				if (line.size() == 0)
					line.insert(line.size(), CH_LF);
				eot_last = 1'b1;
			end
			default: line.insert(line.size(), CH_LF);
		endcase
		foreach (line[i])
			add_byte(line[i], eot_last && i == line.size() - 1);
	endfunction

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		int rand_start;
		// header mark after leading blank, quoted escapes, comma in quotes, held blanks
		add_text(" #a\t\"b\\t\\n\\r\\x,\"  ,c\\d \n");
		add_text("\n");
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(CH_LF, 1'b1);
		// one very wide record to saturate the field index
		repeat (MAX_FIELDS + 2)
			add_byte(CH_COMMA, 1'b0);
		add_text("x\n");
		rand_start = pending_text.size();
		while (pending_text.size() - rand_start < RAND_BYTES)
			add_random_line();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_text.size() != 0 || drv_valid)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS csv_field_tokenizer");
		else
			$display("FAIL csv_field_tokenizer");
		$finish;
	end

	// text driver and token-side ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_ready <= 1'b0;
		end else begin
			drv_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
			if (!drv_valid || text_ch.ready) begin
				if (pending_text.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_req = pending_text.pop_front();
					drv_valid <= 1'b1;
					drv_byte  <= next_req.ch;
					drv_eot   <= next_req.eot;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predict on each accepted byte, check each accepted token
	always @(posedge clk) begin
		if (arst_n) begin
			if (drv_valid && text_ch.ready) begin
				predict_tokens(drv_byte, drv_eot);
				accepted_bytes <= accepted_bytes + 1;
			end
			if (tok_ch.valid && drv_ready) begin
				got = {tok_ch.kind, tok_ch.data_byte, tok_ch.field_number, tok_ch.is_header,
					tok_ch.fields_in_record, tok_ch.widest_record, tok_ch.space_overflow,
					tok_ch.last_of_run};
				if (expected_tokens.size() == 0) begin
					report_failure({"unexpected ", tok_str(got)});
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want)
						report_failure({"expected ", tok_str(want), " got ", tok_str(got)});
				end
				tok_idx++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL csv_field_tokenizer");
			$finish;
		end
	end

endmodule
